// ----- rtl/core/quaternion_to_euler_angles_unit_defines.svh -----
// Assertion macros shared by the quaternion to Euler angle RTL
`ifndef QUATERNION_TO_EULER_ANGLES_UNIT_DEFINES_SVH
`define QUATERNION_TO_EULER_ANGLES_UNIT_DEFINES_SVH

// Condition holds in the same cycle as the trigger
`define QTE_ASSERT_SAME(label, trig, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |-> (cond)) \
        else $error(msg);

// Condition holds in the cycle after the trigger
`define QTE_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ----- rtl/core/qte_pkg.sv -----
`default_nettype none
package qte_pkg;

    localparam int COMP_W     = 16;
    localparam int ANGLE_W    = 16;
    localparam int STAGES     = 16;
    localparam int PROD_W     = 2 * COMP_W;
    localparam int SUM_W      = PROD_W + 3;
    localparam int SP_W       = 29;
    localparam int SQ_W       = 56;
    localparam int ROOT_STEPS = SQ_W / 2 + 1;
    localparam int ROOT_W     = ROOT_STEPS;
    localparam int VEC_W      = SUM_W + 3;
    localparam int ACC_W      = 35;
    localparam int OUT_SHIFT  = 33 - ANGLE_W;
    localparam int RND_W      = ACC_W + 1 - OUT_SHIFT;
    localparam int LATENCY    = 4 + (ROOT_STEPS + 1) + (STAGES + 1) + 1;

    localparam longint Q_PI_L      = 64'sd3373259426;
    localparam longint Q_HALF_PI_L = 64'sd1686629713;
    localparam longint ONE_Q28_L   = 64'sd268435456;
    localparam longint PI_OUT_L    = (Q_PI_L + (64'sd1 <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
    localparam longint HPI_OUT_L   =
        (Q_HALF_PI_L + (64'sd1 <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;

    localparam logic signed [ACC_W-1:0]   Q_PI    = ACC_W'(Q_PI_L);
    localparam logic signed [SUM_W-1:0]   ONE_Q28 = SUM_W'(ONE_Q28_L);
    localparam logic signed [ANGLE_W-1:0] PI_OUT  = ANGLE_W'(PI_OUT_L);
    localparam logic signed [ANGLE_W-1:0] HPI_OUT = ANGLE_W'(HPI_OUT_L);

    // Sums and clamp flag that travel beside the square root
    typedef struct packed {
        logic signed [SUM_W-1:0] sr;
        logic signed [SUM_W-1:0] cr;
        logic signed [SUM_W-1:0] sp;
        logic signed [SUM_W-1:0] sy;
        logic signed [SUM_W-1:0] cy;
        logic                    clamp;
    } side_t;

    // Arctangent of 2^-i, radians with 30 fraction bits
    function automatic logic signed [ACC_W-1:0] stage_angle(input int i);
        logic signed [ACC_W-1:0] a;
        case (i)
            0:       a = ACC_W'(64'sd843314857);
            1:       a = ACC_W'(64'sd497837829);
            2:       a = ACC_W'(64'sd263043837);
            3:       a = ACC_W'(64'sd133525159);
            4:       a = ACC_W'(64'sd67021687);
            5:       a = ACC_W'(64'sd33543516);
            6:       a = ACC_W'(64'sd16775851);
            7:       a = ACC_W'(64'sd8388437);
            8:       a = ACC_W'(64'sd4194283);
            9:       a = ACC_W'(64'sd2097149);
            10:      a = ACC_W'(64'sd1048576);
            default: a = (i <= 30) ? ACC_W'(64'sd1 <<< (30 - i)) : '0;
        endcase
        return a;
    endfunction

    // Round half up to output scale, then saturate to +-bound
    function automatic logic signed [ANGLE_W-1:0] to_angle(
        input logic signed [ACC_W-1:0]   z,
        input logic signed [ANGLE_W-1:0] bound
    );
        logic signed [ACC_W:0]   t;
        logic signed [RND_W-1:0] q;
        logic signed [RND_W-1:0] b;
        logic signed [ANGLE_W-1:0] r;
        t = (ACC_W+1)'(z) + (ACC_W+1)'(64'sd1 <<< (OUT_SHIFT - 1));
        q = t[ACC_W:OUT_SHIFT];
        b = RND_W'(bound);
        if (q > b) begin
            r = bound;
        end else if (q < -b) begin
            r = -bound;
        end else begin
            r = q[ANGLE_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/qte_isqrt.sv -----
`default_nettype none
module qte_isqrt
    import qte_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              en,
    input  wire logic [SQ_W:0]     rem,
    input  wire side_t             side_in,
    output logic      [ROOT_W-1:0] root,
    output side_t                  side_out
);

    logic [SQ_W:0]   n_reg   [0:ROOT_STEPS];
    logic [SQ_W+1:0] res_reg [0:ROOT_STEPS];
    side_t           side_reg[0:ROOT_STEPS];

    // Capture the radicand
    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg[0]    <= rem;
            res_reg[0]  <= '0;
            side_reg[0] <= side_in;
        end
    end

    // One result bit per stage, restoring method
    for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_step
        localparam logic [SQ_W+1:0] BIT = (SQ_W+2)'(1) << (SQ_W - 2 * k);
        logic [SQ_W+1:0] trial;
        logic [SQ_W:0]   n_next;
        logic [SQ_W+1:0] res_next;

        always_comb begin
            trial = res_reg[k] + BIT;
            if ({1'b0, n_reg[k]} >= trial) begin
                n_next   = n_reg[k] - trial[SQ_W:0];
                res_next = (res_reg[k] >> 1) + BIT;
            end else begin
                n_next   = n_reg[k];
                res_next = res_reg[k] >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                n_reg[k+1]    <= n_next;
                res_reg[k+1]  <= res_next;
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign root     = res_reg[ROOT_STEPS][ROOT_W-1:0];
    assign side_out = side_reg[ROOT_STEPS];

endmodule
`default_nettype wire

// ----- rtl/core/qte_atan2.sv -----
`default_nettype none
module qte_atan2
    import qte_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    en,
    input  wire logic signed [SUM_W-1:0] y_in,
    input  wire logic signed [SUM_W-1:0] x_in,
    output logic signed      [ACC_W-1:0] angle
);

    logic signed [VEC_W-1:0] x_reg   [0:STAGES];
    logic signed [VEC_W-1:0] y_reg   [0:STAGES];
    logic signed [ACC_W-1:0] z_reg   [0:STAGES];
    logic                    zero_reg[0:STAGES];

    logic signed [VEC_W-1:0] xe;
    logic signed [VEC_W-1:0] ye;

    // Fold the left half plane onto the right
    assign xe = VEC_W'(x_in);
    assign ye = VEC_W'(y_in);

    always_ff @(posedge aclk) begin
        if (en) begin
            zero_reg[0] <= (x_in == '0) && (y_in == '0);
            if (x_in < 0) begin
                x_reg[0] <= -xe;
                y_reg[0] <= -ye;
                z_reg[0] <= (y_in >= 0) ? Q_PI : -Q_PI;
            end else begin
                x_reg[0] <= xe;
                y_reg[0] <= ye;
                z_reg[0] <= '0;
            end
        end
    end

    // Vectoring micro-rotations, one per stage
    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        localparam logic signed [ACC_W-1:0] ANG = stage_angle(i);
        always_ff @(posedge aclk) begin
            if (en) begin
                zero_reg[i+1] <= zero_reg[i];
                if (y_reg[i] >= 0) begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ANG;
                end else begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ANG;
                end
            end
        end
    end

    assign angle = zero_reg[STAGES] ? '0 : z_reg[STAGES];

endmodule
`default_nettype wire

// ----- rtl/core/quaternion_to_euler_angles_unit.sv -----
// Each accepted item reaches the master side through the output register.
// Throughput: one item per cycle unless m_tready stalls; the products, the 29-stage
// square root and the three 17-stage CORDIC lanes are fully pipelined.
// A stall on m_tready freezes the whole pipeline; nothing is dropped.
// Reset (aresetn low, synchronous) clears the valid bits only.
`default_nettype none
`include "quaternion_to_euler_angles_unit_defines.svh"
module quaternion_to_euler_angles_unit
    import qte_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,  // quat_w, quat_x, quat_y, quat_z
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,  // roll_angle, pitch_angle, yaw_angle, pad
    output logic [0:0]       m_tuser   // pitch_clamped
);

    logic stage_en;
    logic [LATENCY:1] vld_reg;

    logic signed [COMP_W-1:0] w_reg, x_reg, y_reg, z_reg;
    logic signed [PROD_W-1:0] wx_reg, yz_reg, xx_reg, yy_reg, wy_reg;
    logic signed [PROD_W-1:0] zx_reg, wz_reg, xy_reg, zz_reg;
    side_t                    s3_reg, s4_reg, s4_next, side_q;
    logic [SQ_W:0]            sq_reg;
    logic [SQ_W:0]            rem;
    logic signed [SP_W-1:0]   sp29;
    logic signed [2*SP_W-1:0] sp_sq;
    logic [ROOT_W-1:0]        root;
    logic signed [ACC_W-1:0]  roll_z, pitch_z, yaw_z;
    logic [1:0]               flag_reg[0:STAGES];
    logic signed [ANGLE_W-1:0] pitch_full;
    logic [47:0]              m_tdata_reg;
    logic                     m_tuser_reg;

    // Advance whenever the output register is free or being taken
    assign stage_en = !vld_reg[LATENCY] || m_tready;
    assign s_tready = stage_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (stage_en) begin
            vld_reg <= {vld_reg[LATENCY-1:1], s_tvalid};
        end
    end

    // Capture components, form products and the five sums, then register the clamp flag and squared sine
    always_ff @(posedge aclk) begin
        if (stage_en) begin
            w_reg  <= s_tdata[15:0];
            x_reg  <= s_tdata[31:16];
            y_reg  <= s_tdata[47:32];
            z_reg  <= s_tdata[63:48];
            wx_reg <= w_reg * x_reg;
            yz_reg <= y_reg * z_reg;
            xx_reg <= x_reg * x_reg;
            yy_reg <= y_reg * y_reg;
            wy_reg <= w_reg * y_reg;
            zx_reg <= z_reg * x_reg;
            wz_reg <= w_reg * z_reg;
            xy_reg <= x_reg * y_reg;
            zz_reg <= z_reg * z_reg;
            s3_reg.sr    <= (SUM_W'(wx_reg) + SUM_W'(yz_reg)) <<< 1;
            s3_reg.cr    <= ONE_Q28 - ((SUM_W'(xx_reg) + SUM_W'(yy_reg)) <<< 1);
            s3_reg.sp    <= (SUM_W'(wy_reg) - SUM_W'(zx_reg)) <<< 1;
            s3_reg.sy    <= (SUM_W'(wz_reg) + SUM_W'(xy_reg)) <<< 1;
            s3_reg.cy    <= ONE_Q28 - ((SUM_W'(yy_reg) + SUM_W'(zz_reg)) <<< 1);
            s3_reg.clamp <= 1'b0;
            s4_reg <= s4_next;
            sq_reg <= (SQ_W+1)'(sp_sq);
        end
    end

    // Flag saturated pitch and square the sine
    always_comb begin
        s4_next       = s3_reg;
        s4_next.clamp = (s3_reg.sp >= ONE_Q28) || (s3_reg.sp <= -ONE_Q28);
        sp29          = s3_reg.sp[SP_W-1:0];
        sp_sq         = sp29 * sp29;
    end

    assign rem = ((SQ_W+1)'(1) << SQ_W) - sq_reg;

    qte_isqrt u_isqrt (
        .aclk     (aclk),
        .en       (stage_en),
        .rem      (rem),
        .side_in  (s4_reg),
        .root     (root),
        .side_out (side_q)
    );

    qte_atan2 u_roll (
        .aclk  (aclk),
        .en    (stage_en),
        .y_in  (side_q.sr),
        .x_in  (side_q.cr),
        .angle (roll_z)
    );

    qte_atan2 u_pitch (
        .aclk  (aclk),
        .en    (stage_en),
        .y_in  (side_q.sp),
        .x_in  (SUM_W'(root)),
        .angle (pitch_z)
    );

    qte_atan2 u_yaw (
        .aclk  (aclk),
        .en    (stage_en),
        .y_in  (side_q.sy),
        .x_in  (side_q.cy),
        .angle (yaw_z)
    );

    // Carry clamp flag and sine sign beside the CORDIC lanes
    always_ff @(posedge aclk) begin
        if (stage_en) begin
            flag_reg[0] <= {side_q.sp > 0, side_q.clamp};
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_flag
        always_ff @(posedge aclk) begin
            if (stage_en) begin
                flag_reg[i+1] <= flag_reg[i];
            end
        end
    end

    // Round, saturate and register the result item
    always_comb begin
        if (flag_reg[STAGES][0]) begin
            pitch_full = flag_reg[STAGES][1] ? HPI_OUT : -HPI_OUT;
        end else begin
            pitch_full = to_angle(pitch_z, HPI_OUT);
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en) begin
            m_tdata_reg <= {1'b0, to_angle(yaw_z, PI_OUT), pitch_full[ANGLE_W-2:0],
                            to_angle(roll_z, PI_OUT)};
            m_tuser_reg <= flag_reg[STAGES][0];
        end
    end

    assign m_tvalid   = vld_reg[LATENCY];
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    `QTE_ASSERT_NEXT(a_accept_enters, s_tvalid && s_tready, vld_reg[1], "accepted item lost")
    `QTE_ASSERT_NEXT(a_stall_freezes, !stage_en, $stable(vld_reg), "valid moved in stall")
    `QTE_ASSERT_SAME(a_clamp_pitch, m_tvalid && m_tuser[0],
        ($signed(m_tdata[30:16]) == HPI_OUT) || ($signed(m_tdata[30:16]) == -HPI_OUT),
        "clamped pitch not at half pi")
    `QTE_ASSERT_SAME(a_roll_range, m_tvalid,
        ($signed(m_tdata[15:0]) <= PI_OUT) && ($signed(m_tdata[15:0]) >= -PI_OUT),
        "roll out of range")

endmodule
`default_nettype wire
